### sv/assert_macros.svh
// Assertion macros shared by the checker modules.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Check a property on every clock edge outside reset.
`define ASSERT_RUN(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

### sv/scp_pkg.sv
// Shared types and constants of the sine/cosine polynomial pipeline.
// No dependencies; used by scp_reduce, scp_poly and the top level.
package scp_pkg;

  // Quadrant of the reduced angle
  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_t;

  // Angle constants, Q.30, rounded to nearest
  localparam logic [30:0] HALF_PI       = 31'd1686629713;
  localparam logic [31:0] PI            = 32'd3373259426;
  localparam logic [32:0] THREE_HALF_PI = 33'd5059889139;
  localparam logic [32:0] TWO_PI        = 33'd6746518852;

  // Q1.30 unity and rounding half
  localparam logic signed [31:0] ONE   = 32'sd1073741824;
  localparam logic [29:0]        ROUND = 30'd536870912;

  // Polynomial coefficients c1..c5, Q.30
  localparam logic signed [31:0] POLY_C [5] = '{
    32'sd1073741774,
    -32'sd536869896,
    32'sd44735933,
    -32'sd1487530,
    32'sd24861
  };

endpackage

### sv/scp_reduce.sv
// Angle reduction: sine offset, absolute value, modulo 2*pi and quadrant fold.
// Depends on scp_pkg.
module scp_reduce (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_kind,
  input  logic signed [31:0]   in_angle,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [30:0]          out_y,
  output scp_pkg::quad_t       out_quad
);

  localparam int NSTG = 10;
  localparam int NMOD = 6;
  localparam int QSTG = NMOD + 2;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;
  logic [NSTG-1:0] vld_in;

  logic signed [38:0] ang_x;
  logic signed [38:0] ang_s;
  logic signed [38:0] ang_neg;
  logic [37:0]        mag;
  logic [37:0]        rem [NMOD];
  logic [32:0]        r8;
  scp_pkg::quad_t     quad8;
  scp_pkg::quad_t     quad8_next;
  logic [30:0]        y9;
  scp_pkg::quad_t     quad9;

  // A stage advances when it is empty or the next one advances
  genvar i;
  generate
    for (i = 0; i < NSTG; i++) begin : g_adv
      if (i == NSTG - 1) begin : g_last
        assign adv[i] = !vld[i] || out_ready;
      end else begin : g_mid
        assign adv[i] = !vld[i] || adv[i+1];
      end
    end
  endgenerate

  assign vld_in = {vld[NSTG-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (adv[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  // Stage 0: widen to Q.30, offset by pi/2 for sine
  assign ang_x = $signed({in_angle[31], in_angle, 6'b0});

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ang_s <= in_kind ? $signed({8'b0, scp_pkg::HALF_PI}) - ang_x : ang_x;
    end
  end

  // Stage 1: absolute value
  assign ang_neg = -ang_s;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      mag <= ang_s[38] ? ang_neg[37:0] : ang_s[37:0];
    end
  end

  // Stages 2..7: restoring reduction by 2*pi, one quotient bit per stage
  genvar j;
  generate
    for (j = 0; j < NMOD; j++) begin : g_mod
      localparam logic [37:0] STEP = {5'b0, scp_pkg::TWO_PI} << (NMOD - 1 - j);
      logic [37:0] src;
      if (j == 0) begin : g_first
        assign src = mag;
      end else begin : g_next
        assign src = rem[j-1];
      end
      always_ff @(posedge clk) begin
        if (adv[2+j]) begin
          rem[j] <= (src >= STEP) ? src - STEP : src;
        end
      end
    end
  endgenerate

  // Stage 8: quadrant from the reduced angle
  always_comb begin
    priority if ({5'b0, rem[NMOD-1][32:0]} < {7'b0, scp_pkg::HALF_PI}) begin
      quad8_next = scp_pkg::QUAD_0;
    end else if (rem[NMOD-1][32:0] < {1'b0, scp_pkg::PI}) begin
      quad8_next = scp_pkg::QUAD_1;
    end else if (rem[NMOD-1][32:0] < scp_pkg::THREE_HALF_PI) begin
      quad8_next = scp_pkg::QUAD_2;
    end else begin
      quad8_next = scp_pkg::QUAD_3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[QSTG]) begin
      r8    <= rem[NMOD-1][32:0];
      quad8 <= quad8_next;
    end
  end

  // Stage 9: fold into [0, pi/2]
  always_ff @(posedge clk) begin
    if (adv[QSTG+1]) begin
      quad9 <= quad8;
      unique case (quad8)
        scp_pkg::QUAD_0: y9 <= r8[30:0];
        scp_pkg::QUAD_1: y9 <= 31'({1'b0, scp_pkg::PI} - r8);
        scp_pkg::QUAD_2: y9 <= 31'(r8 - {1'b0, scp_pkg::PI});
        scp_pkg::QUAD_3: y9 <= 31'(scp_pkg::TWO_PI - r8);
        default:         y9 <= r8[30:0];
      endcase
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[NSTG-1];
  assign out_y     = y9;
  assign out_quad  = quad9;

endmodule

### sv/scp_poly.sv
// Even polynomial in Horner form: square, then four multiply/add stage pairs.
// Depends on scp_pkg.
module scp_poly (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [30:0]          in_y,
  input  scp_pkg::quad_t       in_quad,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_poly,
  output scp_pkg::quad_t       out_quad
);

  localparam int NTERM = 4;
  localparam int NSTG  = 2 * NTERM + 1;
  localparam int NX2   = NSTG - 2;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;
  logic [NSTG-1:0] vld_in;

  logic [62:0]          sq_sum;
  logic [31:0]          x2_q   [NX2];
  scp_pkg::quad_t       quad_q [NSTG];
  logic signed [63:0]   prod_q [NTERM];
  logic signed [31:0]   t_q    [NTERM];

  genvar i;
  generate
    for (i = 0; i < NSTG; i++) begin : g_adv
      if (i == NSTG - 1) begin : g_last
        assign adv[i] = !vld[i] || out_ready;
      end else begin : g_mid
        assign adv[i] = !vld[i] || adv[i+1];
      end
    end
  endgenerate

  assign vld_in = {vld[NSTG-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (adv[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  // Stage 0: y^2, rounded to nearest
  assign sq_sum = 63'(in_y) * 63'(in_y) + 63'(scp_pkg::ROUND);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      x2_q[0]   <= sq_sum[61:30];
      quad_q[0] <= in_quad;
    end
  end

  // Carry x2 and the quadrant down the pipe
  genvar s;
  generate
    for (s = 1; s < NSTG; s++) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv[s]) begin
          quad_q[s] <= quad_q[s-1];
        end
      end
      if (s < NX2) begin : g_x2
        always_ff @(posedge clk) begin
          if (adv[s]) begin
            x2_q[s] <= x2_q[s-1];
          end
        end
      end
    end
  endgenerate

  // Horner terms: multiply stage, then round-and-add stage
  genvar h;
  generate
    for (h = 0; h < NTERM; h++) begin : g_term
      localparam logic signed [63:0] COEF_SH =
        64'(scp_pkg::POLY_C[NTERM-1-h]) <<< 30;
      logic signed [31:0] t_prev;
      logic signed [64:0] mul_res;
      logic signed [63:0] rnd;
      logic signed [63:0] sum;

      if (h == 0) begin : g_first
        assign t_prev = scp_pkg::POLY_C[NTERM];
      end else begin : g_next
        assign t_prev = t_q[h-1];
      end

      assign mul_res = t_prev * $signed({1'b0, x2_q[2*h]});

      always_ff @(posedge clk) begin
        if (adv[2*h+1]) begin
          prod_q[h] <= mul_res[63:0];
        end
      end

      // Ties go up on non-negative products and down on negative ones: one less offset on negative products
      assign rnd = prod_q[h][63] ? $signed({34'b0, scp_pkg::ROUND}) - 64'sd1
                                 : $signed({34'b0, scp_pkg::ROUND});
      assign sum = prod_q[h] + COEF_SH + rnd;

      always_ff @(posedge clk) begin
        if (adv[2*h+2]) begin
          t_q[h] <= sum[61:30];
        end
      end
    end
  endgenerate

  assign in_ready  = adv[0];
  assign out_valid = vld[NSTG-1];
  assign out_poly  = t_q[NTERM-1];
  assign out_quad  = quad_q[NSTG-1];

endmodule

### sv/sine_cosine_polynomial.sv
// A transaction runs through scp_reduce, scp_poly and the output register.
// Throughput: one transaction per cycle while m_tready allows; every stage holds
// a valid bit and advances when empty or when its successor advances, so bubbles
// collapse. A stalled m_tready freezes only the full stages behind it.
// Reset (rst, synchronous, active high) clears all valid bits; data is not reset.
// Depends on scp_pkg, scp_reduce and scp_poly.
module sine_cosine_polynomial (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] angle, signed Q8.24 radians
  input  logic        s_tuser,   // [0] kind: 0 cosine, 1 sine
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [31:0] value, signed Q1.30
);

  // Reduction to polynomial
  logic               red_valid;
  logic               red_ready;
  logic [30:0]        red_y;
  scp_pkg::quad_t     red_quad;

  // Polynomial to output
  logic               pol_valid;
  logic               pol_ready;
  logic signed [31:0] pol_val;
  scp_pkg::quad_t     pol_quad;

  logic signed [31:0] signed_val;
  logic signed [31:0] sat_val;
  logic               out_adv;

  // Ten stages: sine offset, absolute value, six reduction steps by 2*pi,
  // quadrant select and fold into [0, pi/2]
  scp_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_kind   (s_tuser),
    .in_angle  ($signed(s_tdata)),
    .out_valid (red_valid),
    .out_ready (red_ready),
    .out_y     (red_y),
    .out_quad  (red_quad)
  );

  // Nine stages: square, then four Horner multiply/add pairs
  scp_poly u_poly (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (red_valid),
    .in_ready  (red_ready),
    .in_y      (red_y),
    .in_quad   (red_quad),
    .out_valid (pol_valid),
    .out_ready (pol_ready),
    .out_poly  (pol_val),
    .out_quad  (pol_quad)
  );

  // Negate in the second and third quadrants, then clamp to plus or minus one
  always_comb begin
    if (pol_quad == scp_pkg::QUAD_1 || pol_quad == scp_pkg::QUAD_2) begin
      signed_val = -pol_val;
    end else begin
      signed_val = pol_val;
    end
    priority if (signed_val > scp_pkg::ONE) begin
      sat_val = scp_pkg::ONE;
    end else if (signed_val < -scp_pkg::ONE) begin
      sat_val = -scp_pkg::ONE;
    end else begin
      sat_val = signed_val;
    end
  end

  // Output register: load when empty or when the sink takes the current result
  assign out_adv   = !m_tvalid || m_tready;
  assign pol_ready = out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_tvalid <= pol_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && pol_valid) begin
      m_tdata <= sat_val;
    end
  end

endmodule

### sv/scp_checker.sv
// Port-level checks for sine_cosine_polynomial, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module scp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // No result may survive a reset
  `ASSERT_ALWAYS(a_rst_clears, clk, rst |=> !m_tvalid, "result valid after reset")

  // A held result keeps its value
  `ASSERT_RUN(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

  // Saturated output stays within plus or minus one
  `ASSERT_RUN(a_range, clk, rst, m_tvalid |-> ($signed(m_tdata) <= 32'sd1073741824 && $signed(m_tdata) >= -32'sd1073741824), "result out of range")

  // Input backpressure only comes from a stalled, full output
  `ASSERT_RUN(a_bp, clk, rst, !s_tready |-> m_tvalid && !m_tready, "input stalled while output free")

endmodule

bind sine_cosine_polynomial scp_checker u_scp_checker (.*);
